// ===== rtl/sbf_pkg.sv =====
// Shared types, constants and a helper function of the string Bloom filter.
package sbf_pkg;

    localparam int unsigned NUM_HASH = 4;
    localparam int unsigned LANE_W   = 2;
    localparam int unsigned HASH_W   = 20;
    localparam int unsigned T_W      = HASH_W + 2;
    localparam int unsigned CM_W     = 6;
    localparam int unsigned STEP_W   = 3;
    localparam int unsigned ROW_SH   = 6;
    localparam int unsigned ROW_BITS = 64;
    localparam int unsigned ROW_AW   = HASH_W - ROW_SH;
    localparam int unsigned REQ_W    = 2;
    localparam int unsigned CHAR_W   = 8;

    localparam logic [CM_W-1:0] HASH_BASE = 6'd37;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FIND   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NOP    = 2'd3;

    typedef logic [NUM_HASH-1:0][HASH_W-1:0] hash_vec_t;
    typedef logic [ROW_BITS-1:0] row_t;

    typedef struct packed {
        logic            start;
        logic            restart;
        logic [CM_W-1:0] cm;
    } hash_ctl_t;

    // Reduces a character code modulo the hash base by conditional subtraction.
    function automatic logic [CM_W-1:0] char_mod37(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        for (int i = 0; i < 6; i++)
        begin
            if (r >= CHAR_W'(HASH_BASE))
            begin
                r = r - CHAR_W'(HASH_BASE);
            end
        end
        return r[CM_W-1:0];
    endfunction

endpackage

// ===== rtl/sbf_req_if.sv =====
// Request channel: at most one key character per transaction.
interface sbf_req_if
    import sbf_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [CHAR_W-1:0] char_code;
    logic              char_present;
    logic              last_of_key;

    modport source (output valid, output req_type, output char_code,
                    output char_present, output last_of_key, input ready);
    modport sink   (input valid, input req_type, input char_code,
                    input char_present, input last_of_key, output ready);
endinterface

// ===== rtl/sbf_rsp_if.sv =====
// Response channel: one completed request per transaction.
interface sbf_rsp_if
    import sbf_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             found;
    logic [REQ_W-1:0] done_kind;

    modport source (output valid, output found, output done_kind, input ready);
    modport sink   (input valid, input found, input done_kind, output ready);
endinterface

// ===== rtl/sbf_hash_unit.sv =====
// Four running polynomial hashes updated by one shared modular shift-add step.
module sbf_hash_unit
    import sbf_pkg::*;
#(
    parameter int unsigned MOD_A = 999983,
    parameter int unsigned MOD_B = 1000039,
    parameter int unsigned MOD_C = 313333,
    parameter int unsigned MOD_D = 213337
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  hash_ctl_t ctl,
    output logic      busy,
    output hash_vec_t hashes
);

    localparam logic [STEP_W-1:0] STEP_FIRST = STEP_W'(CM_W - 1);
    localparam logic [LANE_W-1:0] LANE_LAST  = LANE_W'(NUM_HASH - 1);

    hash_vec_t         run_reg;
    logic [HASH_W-1:0] acc_reg;
    logic [LANE_W-1:0] lane_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CM_W-1:0]   cm_reg;
    logic              busy_reg;

    logic [T_W-1:0]    mod_val;
    logic [T_W-1:0]    mod_dbl;
    logic [T_W-1:0]    sum;
    logic [T_W-1:0]    reduced;
    logic [HASH_W-1:0] acc_next;

    // One Horner step over bit positions of 37 and of the reduced character:
    // acc = (2 * acc + bit37 * h + bitc) mod M, where the sum stays below 3M.
    always_comb
    begin
        case (lane_reg)
            2'd0:    mod_val = T_W'(MOD_A);
            2'd1:    mod_val = T_W'(MOD_B);
            2'd2:    mod_val = T_W'(MOD_C);
            default: mod_val = T_W'(MOD_D);
        endcase
        mod_dbl = mod_val << 1;
        sum = (T_W'(acc_reg) << 1)
            + (HASH_BASE[step_reg] ? T_W'(run_reg[lane_reg]) : '0)
            + T_W'(cm_reg[step_reg]);
        if (sum >= mod_dbl)
        begin
            reduced = sum - mod_dbl;
        end
        else if (sum >= mod_val)
        begin
            reduced = sum - mod_val;
        end
        else
        begin
            reduced = sum;
        end
        acc_next = reduced[HASH_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= '0;
            acc_reg  <= '0;
            lane_reg <= '0;
            step_reg <= STEP_FIRST;
            cm_reg   <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            if (ctl.restart)
            begin
                run_reg <= '0;
            end
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                lane_reg <= '0;
                step_reg <= STEP_FIRST;
                acc_reg  <= '0;
                cm_reg   <= ctl.cm;
            end
            else if (busy_reg)
            begin
                if (step_reg == '0)
                begin
                    run_reg[lane_reg] <= acc_next;
                    acc_reg           <= '0;
                    step_reg          <= STEP_FIRST;
                    if (lane_reg == LANE_LAST)
                    begin
                        busy_reg <= 1'b0;
                    end
                    else
                    begin
                        lane_reg <= lane_reg + 1'b1;
                    end
                end
                else
                begin
                    acc_reg  <= acc_next;
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    assign busy   = busy_reg;
    assign hashes = run_reg;

endmodule

// ===== rtl/sbf_bit_mem.sv =====
// Single-port bit memory organized in rows with a registered read.
module sbf_bit_mem
    import sbf_pkg::*;
#(
    parameter int unsigned MOD = 999983
)
(
    input  logic              clk,
    input  logic              re,
    input  logic              we,
    input  logic [ROW_AW-1:0] addr,
    input  row_t              wdata,
    output row_t              rdata
);

    localparam int unsigned ROWS = (MOD + ROW_BITS - 1) / ROW_BITS;
    localparam int unsigned AW   = (ROWS > 1) ? $clog2(ROWS) : 1;

    row_t          mem [ROWS];
    logic [AW-1:0] idx;
    logic          in_range;

    assign idx      = addr[AW-1:0];
    assign in_range = {1'b0, addr} < (ROW_AW + 1)'(ROWS);

    always_ff @(posedge clk)
    begin
        if (we && in_range)
        begin
            mem[idx] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[idx];
        end
    end

endmodule

// ===== rtl/string_bloom_filter.sv =====
// Top level of the string Bloom filter with four polynomial hashes.
// An item with a character runs 24 steps of the shared modular unit (six per hash), then
// S_HASH sees it finish and S_DECIDE decides; an item without one goes straight to S_DECIDE.
// A key end for insert or find reads the rows, then updates or tests them, before the result.
// A clear sweeps ceil(max(MOD)/64) rows, 15626 rows at the default moduli, then responds.
// After reset the same sweep runs and the request channel is not ready until it ends.
module string_bloom_filter
    import sbf_pkg::*;
#(
    parameter int unsigned MOD_A = 999983,
    parameter int unsigned MOD_B = 1000039,
    parameter int unsigned MOD_C = 313333,
    parameter int unsigned MOD_D = 213337
)
(
    input logic       clk,
    input logic       rst_n,
    sbf_req_if.sink   req,
    sbf_rsp_if.source rsp
);

    localparam int unsigned MODS [NUM_HASH] = '{MOD_A, MOD_B, MOD_C, MOD_D};
    localparam int unsigned MAX_AB  = (MOD_A > MOD_B) ? MOD_A : MOD_B;
    localparam int unsigned MAX_CD  = (MOD_C > MOD_D) ? MOD_C : MOD_D;
    localparam int unsigned MAX_MOD = (MAX_AB > MAX_CD) ? MAX_AB : MAX_CD;
    localparam int unsigned MAX_ROWS = (MAX_MOD + ROW_BITS - 1) / ROW_BITS;
    localparam logic [ROW_AW-1:0] CLR_LAST = ROW_AW'(MAX_ROWS - 1);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_HASH,
        S_DECIDE,
        S_MODIFY,
        S_CLEAR,
        S_DONE
    } state_t;

    state_t            state_reg;
    logic [REQ_W-1:0]  req_type_reg;
    logic              last_reg;
    logic [ROW_AW-1:0] clr_cnt_reg;
    logic              res_found_reg;
    logic              out_valid_reg;
    logic              out_found_reg;
    logic [REQ_W-1:0]  out_kind_reg;

    hash_ctl_t         hash_ctl;
    logic              hash_busy;
    hash_vec_t         hash_vec;

    logic              accept;
    logic              out_free;
    logic              lookup;
    logic              clearing;
    logic [NUM_HASH-1:0] mem_re;
    logic [NUM_HASH-1:0] mem_we;
    logic [NUM_HASH-1:0] hit;
    logic [ROW_AW-1:0] mem_addr  [NUM_HASH];
    row_t              mem_wdata [NUM_HASH];
    row_t              mem_rdata [NUM_HASH];
    logic [ROW_SH-1:0] bit_sel   [NUM_HASH];

    assign req.ready     = (state_reg == S_IDLE);
    assign accept        = req.valid && req.ready;
    assign out_free      = !out_valid_reg || rsp.ready;
    assign rsp.valid     = out_valid_reg;
    assign rsp.found     = out_found_reg;
    assign rsp.done_kind = out_kind_reg;

    assign lookup   = (state_reg == S_DECIDE) && last_reg
                   && (req_type_reg inside {REQ_INSERT, REQ_FIND});
    assign clearing = (state_reg == S_INIT) || (state_reg == S_CLEAR);

    always_comb
    begin
        hash_ctl.start   = accept && req.char_present;
        hash_ctl.cm      = char_mod37(req.char_code);
        hash_ctl.restart = ((state_reg == S_DONE) && out_free)
                        || ((state_reg == S_DECIDE) && last_reg && (req_type_reg == REQ_NOP));
    end

    always_comb
    begin
        for (int i = 0; i < NUM_HASH; i++)
        begin
            bit_sel[i] = hash_vec[i][ROW_SH-1:0];
            hit[i]     = mem_rdata[i][bit_sel[i]];
            mem_re[i]  = lookup;
            if (clearing)
            begin
                mem_we[i]    = 1'b1;
                mem_addr[i]  = clr_cnt_reg;
                mem_wdata[i] = '0;
            end
            else
            begin
                mem_we[i]    = (state_reg == S_MODIFY) && (req_type_reg == REQ_INSERT);
                mem_addr[i]  = hash_vec[i][HASH_W-1:ROW_SH];
                mem_wdata[i] = mem_rdata[i] | (row_t'(1) << bit_sel[i]);
            end
        end
    end

    sbf_hash_unit #(
        .MOD_A (MOD_A),
        .MOD_B (MOD_B),
        .MOD_C (MOD_C),
        .MOD_D (MOD_D)
    ) u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (hash_ctl),
        .busy   (hash_busy),
        .hashes (hash_vec)
    );

    for (genvar g = 0; g < NUM_HASH; g++)
    begin : g_mem
        sbf_bit_mem #(
            .MOD (MODS[g])
        ) u_mem (
            .clk   (clk),
            .re    (mem_re[g]),
            .we    (mem_we[g]),
            .addr  (mem_addr[g]),
            .wdata (mem_wdata[g]),
            .rdata (mem_rdata[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            req_type_reg  <= REQ_INSERT;
            last_reg      <= 1'b0;
            clr_cnt_reg   <= '0;
            res_found_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_found_reg <= 1'b0;
            out_kind_reg  <= REQ_INSERT;
        end
        else
        begin
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.valid && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_INIT:
                begin
                    if (clr_cnt_reg == CLR_LAST)
                    begin
                        clr_cnt_reg <= '0;
                        state_reg   <= S_IDLE;
                    end
                    else
                    begin
                        clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        req_type_reg <= req.req_type;
                        last_reg     <= req.last_of_key;
                        state_reg    <= req.char_present ? S_HASH : S_DECIDE;
                    end
                end
                S_HASH:
                begin
                    if (!hash_busy)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    if (!last_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        case (req_type_reg)
                            REQ_INSERT: state_reg <= S_MODIFY;
                            REQ_FIND:   state_reg <= S_MODIFY;
                            REQ_CLEAR:  state_reg <= S_CLEAR;
                            default:    state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_MODIFY:
                begin
                    res_found_reg <= (req_type_reg == REQ_FIND) && (&hit);
                    state_reg     <= S_DONE;
                end
                S_CLEAR:
                begin
                    if (clr_cnt_reg == CLR_LAST)
                    begin
                        clr_cnt_reg   <= '0;
                        res_found_reg <= 1'b0;
                        state_reg     <= S_DONE;
                    end
                    else
                    begin
                        clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_found_reg <= res_found_reg;
                        out_kind_reg  <= req_type_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // A found flag is only ever reported for a find request.
    a_found_only_find: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.found |-> rsp.done_kind == REQ_FIND)
        else $error("found set on a response that is not a find");

    // A transaction with a character starts the shared hash unit.
    a_hash_starts: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready && req.char_present |=> hash_busy)
        else $error("hash unit did not start on a character");

    // The memories are never written while the hashes are still being updated.
    a_no_write_hashing: assert property (@(posedge clk) disable iff (!rst_n)
        hash_busy |-> mem_we == '0)
        else $error("memory write while hashes are in flight");

    // A response is only loaded after the hash unit has finished.
    a_done_idle_hash: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE |-> !hash_busy)
        else $error("response pending while the hash unit is busy");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench of the string Bloom filter: keys streamed against a Bloom filter predictor.
`timescale 1ns / 100ps

module tb;
    import sbf_pkg::*;

    localparam int unsigned MOD_A = 999983;
    localparam int unsigned MOD_B = 1000039;
    localparam int unsigned MOD_C = 313333;
    localparam int unsigned MOD_D = 213337;
    localparam int unsigned MODULI [NUM_HASH] = '{MOD_A, MOD_B, MOD_C, MOD_D};
    localparam int unsigned HASH_MUL        = 37;
    localparam int unsigned WATCHDOG_LIMIT  = 80000;
    localparam int unsigned DRAIN_CYCLES    = 64;
    localparam int unsigned HOLD_OFF_CYCLES = 600;
    localparam int unsigned RANDOM_ITEMS    = 500;
    localparam int unsigned DIRECTED_ITEMS  = 25;
    localparam int unsigned MAX_CLEARS      = 4;
    localparam int unsigned MAX_REPORTS     = 10;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [CHAR_W-1:0] char_code;
        logic              char_present;
        logic              last_of_key;
    } key_item_t;

    typedef struct packed {
        logic             found;
        logic [REQ_W-1:0] done_kind;
    } outcome_t;

    typedef struct packed {
        logic [7:0][CHAR_W-1:0] chars;
        int unsigned            len;
    } key_rec_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    sbf_req_if req_chan();
    sbf_rsp_if rsp_chan();

    logic      send_valid = 1'b0;
    key_item_t send_item  = '0;
    logic      take_ready = 1'b0;
    logic      hold_off   = 1'b0;

    assign req_chan.valid        = send_valid;
    assign req_chan.req_type     = send_item.req_type;
    assign req_chan.char_code    = send_item.char_code;
    assign req_chan.char_present = send_item.char_present;
    assign req_chan.last_of_key  = send_item.last_of_key;
    assign rsp_chan.ready        = take_ready;

    key_item_t   pending_items[$];
    outcome_t    expected_outcomes[$];
    key_rec_t    stored_keys[$];
    bit          filter_bits[longint unsigned];
    hash_vec_t   run_hash        = '0;
    int unsigned send_gap        = 0;
    int unsigned recv_stall      = 0;
    int unsigned items_sent      = 0;
    int unsigned results_checked = 0;
    int unsigned find_hits       = 0;
    int unsigned clears_seen     = 0;
    int unsigned mismatch_count  = 0;
    int unsigned idle_cycles     = 0;

    always #4 clk = ~clk;

    string_bloom_filter #(
        .MOD_A(MOD_A),
        .MOD_B(MOD_B),
        .MOD_C(MOD_C),
        .MOD_D(MOD_D)
    ) DUT (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_chan),
        .rsp  (rsp_chan)
    );

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        else if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 120);
    endfunction

    function automatic logic [HASH_W-1:0] step_hash(input logic [HASH_W-1:0] h,
                                                    input logic [CHAR_W-1:0] c,
                                                    input int unsigned m);
        longint unsigned hv;
        longint unsigned cv;
        longint unsigned mv;
        longint unsigned t;
        hv = h;
        cv = c;
        mv = m;
        t = (HASH_MUL * hv) % mv;
        t = (t + cv % HASH_MUL) % mv;
        return t[HASH_W-1:0];
    endfunction

    function automatic key_rec_t key_of(input int unsigned n, input logic [63:0] c);
        key_rec_t k;
        k.len   = n;
        k.chars = c;
        return k;
    endfunction

    function automatic logic [CHAR_W-1:0] random_char();
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd37;
            default: return CHAR_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic key_rec_t random_key();
        key_rec_t k;
        int unsigned r;
        r = $urandom_range(0, 9);
        k = '0;
        if (r == 0)
        begin
            k.len = 0;
        end
        else if (r < 8)
        begin
            k.len = $urandom_range(1, 4);
        end
        else
        begin
            k.len = $urandom_range(5, 8);
        end
        for (int i = 0; i < 8; i++)
        begin
            k.chars[i] = random_char();
        end
        return k;
    endfunction

    // Shifting a character by the hash base leaves every running hash unchanged.
    function automatic key_rec_t alias_key(input key_rec_t k);
        key_rec_t a;
        a = k;
        for (int i = 0; i < 8; i++)
        begin
            if (a.chars[i] < 8'd219)
            begin
                a.chars[i] = a.chars[i] + 8'd37;
            end
            else
            begin
                a.chars[i] = a.chars[i] - 8'd37;
            end
        end
        return a;
    endfunction

    task automatic track_request(input key_item_t it);
        longint unsigned slot;
        logic            hit;
        outcome_t        outcome;
        if (it.char_present)
        begin
            for (int lane = 0; lane < NUM_HASH; lane++)
            begin
                run_hash[lane] = step_hash(run_hash[lane], it.char_code, MODULI[lane]);
            end
        end
        if (it.last_of_key)
        begin
            hit = 1'b1;
            for (int lane = 0; lane < NUM_HASH; lane++)
            begin
                slot = lane;
                slot = (slot << 32) | run_hash[lane];
                if (it.req_type == REQ_INSERT)
                begin
                    filter_bits[slot] = 1'b1;
                end
                else if (!filter_bits.exists(slot))
                begin
                    hit = 1'b0;
                end
            end
            outcome.done_kind = it.req_type;
            outcome.found     = 1'b0;
            case (it.req_type)
                REQ_INSERT: expected_outcomes.push_back(outcome);
                REQ_FIND:
                begin
                    outcome.found = hit;
                    expected_outcomes.push_back(outcome);
                end
                REQ_CLEAR:
                begin
                    filter_bits.delete();
                    expected_outcomes.push_back(outcome);
                end
                default: ;
            endcase
            run_hash = '0;
        end
    endtask

    task automatic add_request(input logic [REQ_W-1:0] kind, input key_rec_t k,
                               input logic [REQ_W-1:0] filler, input bit holes,
                               input bit split_end);
        key_item_t it;
        for (int i = 0; i < k.len; i++)
        begin
            if (holes && $urandom_range(0, 6) == 0)
            begin
                it.req_type     = filler;
                it.char_code    = CHAR_W'($urandom_range(0, 255));
                it.char_present = 1'b0;
                it.last_of_key  = 1'b0;
                pending_items.push_back(it);
            end
            it.last_of_key  = (i == k.len - 1) && !split_end;
            it.req_type     = it.last_of_key ? kind : filler;
            it.char_code    = k.chars[i];
            it.char_present = 1'b1;
            pending_items.push_back(it);
        end
        if (split_end || k.len == 0)
        begin
            it.req_type     = kind;
            it.char_code    = CHAR_W'($urandom_range(0, 255));
            it.char_present = 1'b0;
            it.last_of_key  = 1'b1;
            pending_items.push_back(it);
        end
    endtask

    task automatic add_noise();
        key_item_t it;
        int unsigned n;
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
        begin
            it.req_type     = REQ_W'($urandom_range(0, 3));
            it.char_code    = CHAR_W'($urandom_range(0, 255));
            it.char_present = 1'($urandom_range(0, 1));
            it.last_of_key  = ($urandom_range(0, 3) == 0);
            pending_items.push_back(it);
        end
    endtask

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
    endtask

    // Request side: at most one key character per transaction, with random gaps in between.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            send_valid <= 1'b0;
        end
        else
        begin
            if (send_valid && req_chan.ready)
            begin
                track_request(send_item);
                items_sent++;
                send_gap = pick_gap();
            end
            if (!send_valid || req_chan.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    send_valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    send_item  <= pending_items.pop_front();
                    send_valid <= 1'b1;
                end
                else
                begin
                    send_valid <= 1'b0;
                end
            end
        end
    end

    // Response side: every completed request is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            take_ready <= 1'b0;
        end
        else
        begin
            if (rsp_chan.valid && take_ready)
            begin
                results_checked++;
                if (expected_outcomes.size() == 0)
                begin
                    note_mismatch($sformatf("unexpected result found=%0b kind=%0d",
                                            rsp_chan.found, rsp_chan.done_kind));
                end
                else
                begin
                    outcome_t want;
                    want = expected_outcomes.pop_front();
                    if (want.found !== rsp_chan.found || want.done_kind !== rsp_chan.done_kind)
                    begin
                        note_mismatch($sformatf("expected found=%0b kind=%0d, got found=%0b kind=%0d",
                                                want.found, want.done_kind,
                                                rsp_chan.found, rsp_chan.done_kind));
                    end
                    if (want.done_kind == REQ_FIND && want.found)
                    begin
                        find_hits++;
                    end
                    if (want.done_kind == REQ_CLEAR)
                    begin
                        clears_seen++;
                    end
                end
            end
            if (hold_off)
            begin
                take_ready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                take_ready <= 1'b0;
            end
            else
            begin
                take_ready <= 1'b1;
                if ($urandom_range(0, 5) == 0)
                begin
                    recv_stall = pick_gap();
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((send_valid && req_chan.ready) || (rsp_chan.valid && take_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Long receiver hold-offs while requests keep coming, so the block backs up.
    initial
    begin
        while (items_sent < 40)
        begin
            @(posedge clk);
        end
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
        while (items_sent < 300)
        begin
            @(posedge clk);
        end
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        key_rec_t         k;
        logic [REQ_W-1:0] kind;
        logic [REQ_W-1:0] filler;
        bit               noisy;
        bit               noise_only;
        int unsigned      pick;
        int unsigned      clears_left;

        add_request(REQ_INSERT, key_of(2, 64'hFF00), REQ_INSERT, 1'b0, 1'b0);
        add_request(REQ_FIND, key_of(2, 64'hFF25), REQ_FIND, 1'b0, 1'b0);
        add_request(REQ_FIND, key_of(1, 64'hFF), REQ_FIND, 1'b0, 1'b0);
        add_request(REQ_INSERT, key_of(0, 64'h0), REQ_INSERT, 1'b0, 1'b0);
        add_request(REQ_FIND, key_of(0, 64'h0), REQ_FIND, 1'b0, 1'b0);
        add_request(REQ_NOP, key_of(2, 64'h4241), REQ_CLEAR, 1'b0, 1'b0);
        add_request(REQ_FIND, key_of(2, 64'hFF00), REQ_NOP, 1'b0, 1'b1);
        add_request(REQ_CLEAR, key_of(2, 64'h0201), REQ_FIND, 1'b0, 1'b0);
        add_request(REQ_FIND, key_of(2, 64'hFF00), REQ_FIND, 1'b0, 1'b0);
        add_request(REQ_INSERT, key_of(4, 64'h017F80FF), REQ_INSERT, 1'b0, 1'b0);
        add_request(REQ_FIND, key_of(4, 64'h017F80FF), REQ_FIND, 1'b0, 1'b1);

        clears_left = MAX_CLEARS;
        while (pending_items.size() < DIRECTED_ITEMS + RANDOM_ITEMS)
        begin
            pick       = $urandom_range(0, 99);
            k          = random_key();
            noisy      = ($urandom_range(0, 3) == 0);
            noise_only = 1'b0;
            kind       = REQ_INSERT;
            if (pick < 40)
            begin
                kind = REQ_INSERT;
            end
            else if (pick < 78)
            begin
                kind = REQ_FIND;
                if (stored_keys.size() != 0 && $urandom_range(0, 9) < 7)
                begin
                    k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
                    if ($urandom_range(0, 2) == 0)
                    begin
                        k = alias_key(k);
                    end
                end
            end
            else if (pick < 81)
            begin
                if (clears_left > 0)
                begin
                    kind = REQ_CLEAR;
                    clears_left--;
                    stored_keys.delete();
                end
            end
            else if (pick < 88)
            begin
                kind = REQ_NOP;
            end
            else
            begin
                noise_only = 1'b1;
            end
            if (noise_only)
            begin
                add_noise();
            end
            else
            begin
                if (kind == REQ_INSERT)
                begin
                    stored_keys.push_back(k);
                end
                filler = noisy ? REQ_W'($urandom_range(0, 3)) : kind;
                add_request(kind, k, filler, noisy, $urandom_range(0, 4) == 0);
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() != 0 || send_valid || expected_outcomes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Streamed %0d key characters and end markers, checked %0d results,",
                 items_sent, results_checked);
        $display("including %0d find hits and %0d full clears.", find_hits, clears_seen);
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
